// ===== src/block_average_char_ramp_unit_assert.svh =====
// Assertion macros for the tile-average character quantizer.
// Included by the top level; no other dependencies.
`ifndef BLOCK_AVERAGE_CHAR_RAMP_UNIT_ASSERT_SVH
`define BLOCK_AVERAGE_CHAR_RAMP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define BACR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bacr: same-cycle check failed");

// Next-cycle implication.
`define BACR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bacr: next-cycle check failed");

`else

`define BACR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BACR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/bacr_pkg.sv =====
// Shared constants, types and helper functions of the tile-average quantizer.
// No dependencies; imported by every other file but the assertion macro header.
package bacr_pkg;

   // Field and storage sizes.
   localparam int PIX_W      = 8;
   localparam int SUM_W      = 16;
   localparam int POS_W      = 12;
   localparam int CFG_W      = 13;
   localparam int BLK_W      = 5;
   localparam int INB_W      = 4;
   localparam int CNT_W      = 9;
   localparam int PROD_W     = 2 * BLK_W;
   localparam int AVG_W      = 8;
   localparam int RIDX_W     = 5;
   localparam int CODE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = 4;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_BLOCK  = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE   = CSR_IDX_W'(2);

   // Register values after reset.
   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);
   localparam logic [BLK_W-1:0] RESET_BLOCK  = BLK_W'(5);

   // One result item.
   typedef struct packed {
      logic [RIDX_W-1:0] ramp_index;
      logic [CODE_W-1:0] char_code;
      logic [AVG_W-1:0]  block_average;
      logic [POS_W-1:0]  block_column;
      logic [POS_W-1:0]  block_row;
      logic              row_end;
      logic              image_end;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic accumulate;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic tile_end;
      logic div_done;
      logic out_free;
   } stat_type;

   // Ramp position 16*avg/255, floor. The division by 255 uses the
   // reciprocal identity x/255 = (x + (x >> 8) + 1) >> 8, exact for x < 65535.
   function automatic logic [RIDX_W-1:0] ramp_index_of(input logic [AVG_W-1:0] avg);
      logic [CFG_W-1:0] scaled;
      logic [CFG_W-1:0] t;
      scaled = CFG_W'({avg, 4'b0000});
      t = scaled + (scaled >> 8) + CFG_W'(1);
      return t[CFG_W-1:8];
   endfunction

   // Character ramp, darkest first: " `.-':_,=+!*s#$%@".
   function automatic logic [CODE_W-1:0] ramp_code_of(input logic [RIDX_W-1:0] idx);
      logic [CODE_W-1:0] code;
      case (idx)
         5'd0:    code = 7'd32;
         5'd1:    code = 7'd96;
         5'd2:    code = 7'd46;
         5'd3:    code = 7'd45;
         5'd4:    code = 7'd39;
         5'd5:    code = 7'd58;
         5'd6:    code = 7'd95;
         5'd7:    code = 7'd44;
         5'd8:    code = 7'd61;
         5'd9:    code = 7'd43;
         5'd10:   code = 7'd33;
         5'd11:   code = 7'd42;
         5'd12:   code = 7'd115;
         5'd13:   code = 7'd35;
         5'd14:   code = 7'd36;
         5'd15:   code = 7'd37;
         5'd16:   code = 7'd64;
         default: code = 7'd32;
      endcase
      return code;
   endfunction

endpackage

// ===== src/bacr_if.sv =====
// Channel interfaces of the tile-average quantizer: pixels, results, registers.
// Depends on bacr_pkg for widths and the result payload type.

// Pixel input channel.
interface bacr_pixel_if import bacr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// Result channel.
interface bacr_rsp_if import bacr_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// Register write channel.
interface bacr_csr_if import bacr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/block_average_char_ramp_unit.sv =====
// Tile-average character quantizer, top level.
// Uses bacr_pkg, the channel interfaces, bacr_ctrl, bacr_dpath and the assert macros.
//
// Pixels enter on req_bus in raster order, one per transfer. Each pixel is added
// to the running sum of its tile column, kept in a 4096-entry memory. On the last
// pixel of a tile the sum is divided by the tile's pixel count and the average is
// mapped to a 17-character ramp; one result then appears on rsp_bus with the tile
// position and row and image end flags. Registers are written on csr_bus, which
// is ready whenever reset is low; any write to width, height or tile size
// restarts the image.
// A pixel that does not close a tile passes through a memory read, then the
// accumulate and write back. A pixel that closes a tile then goes through the
// serial divider, which forms the quotient bit by bit, and the load of the
// output register once it is free; the result is valid in the cycle after the load.
// Reset restores the register defaults and the top-left position and holds both
// input channels not ready; the memory is not cleared, as the first pixel of
// every tile overwrites its entry.
// While a result waits in the output register the next tile's pixels are still
// taken; only a second result stalls until the receiver takes the first one.
`include "block_average_char_ramp_unit_assert.svh"

module block_average_char_ramp_unit import bacr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bacr_pixel_if.sink  req_bus,
   bacr_rsp_if.source  rsp_bus,
   bacr_csr_if.sink    csr_bus
);

   cmd_type  cmd;
   stat_type stat;

   // Register writes are taken at any time outside reset.
   assign csr_bus.ready = !reset;

   // Controller.
   bacr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   bacr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_pixel   (req_bus.pixel),
      .csr_valid   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_payload (rsp_bus.payload)
   );

   // A pixel transfer is followed by the accumulate cycle, never by another transfer.
   `BACR_ASSERT_NEXT(a_acc_after_pixel, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)

   // The output register is loaded only when it is empty or being drained.
   `BACR_ASSERT_NOW(a_load_when_free, clock, reset, cmd.load_out, !rsp_bus.valid || rsp_bus.ready)

   // A load always shows a result in the following cycle.
   `BACR_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_out, rsp_bus.valid)

   // Input is never taken while the divider runs.
   `BACR_ASSERT_NOW(a_no_pixel_in_div, clock, reset, cmd.div_step, !req_bus.ready)

endmodule

// ===== src/bacr_ctrl.sv =====
// Sequencing state machine of the tile-average quantizer.
// Depends on bacr_pkg for the command and status structs.
module bacr_ctrl import bacr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_ACC  = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands. No pixel is taken while reset is high.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = stat.tile_end ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bacr_dpath.sv =====
// Datapath of the tile-average quantizer: registers, position counters,
// tile-column sum memory, serial divider and output register. Uses bacr_pkg.
module bacr_dpath import bacr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload
);

   // Configuration registers.
   logic [CFG_W-1:0] width_ff, height_ff;
   logic [BLK_W-1:0] bsize_ff;
   logic             restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         bsize_ff  <= RESET_BLOCK;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_data;
            REG_BLOCK_SIZE:   bsize_ff  <= csr_data[BLK_W-1:0];
            default: ;
         endcase
      end
   end

   // A write to a listed register sends the position back to the top-left pixel.
   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BLOCK_SIZE: restart = csr_valid;
         default:                                          restart = 1'b0;
      endcase
   end

   // Effective sizes: zero acts as one, oversized values saturate.
   logic [CFG_W-1:0] w_eff, h_eff;
   logic [BLK_W-1:0] b_eff;

   always_comb begin
      if (width_ff == '0)                      w_eff = CFG_W'(1);
      else if (width_ff > CFG_W'(MAX_WIDTH))   w_eff = CFG_W'(MAX_WIDTH);
      else                                     w_eff = width_ff;
      if (height_ff == '0)                     h_eff = CFG_W'(1);
      else if (height_ff > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
      else                                     h_eff = height_ff;
      if (bsize_ff == '0)                      b_eff = BLK_W'(1);
      else if (bsize_ff > BLK_W'(MAX_BLOCK))   b_eff = BLK_W'(MAX_BLOCK);
      else                                     b_eff = bsize_ff;
   end

   // Position counters.
   logic [POS_W-1:0] pcol_ff, prow_ff, tcol_ff, trow_ff;
   logic [POS_W-1:0] pcol_in, prow_in, tcol_in, trow_in;
   logic [INB_W-1:0] cib_ff, rib_ff, cib_in, rib_in;
   logic [BLK_W-1:0] cib_p1, rib_p1;
   logic             last_col, last_row, col_blk_end, row_blk_end;
   logic             tile_end, first_px;
   logic [PROD_W-1:0] count_prod;

   assign last_col    = ({1'b0, pcol_ff} + CFG_W'(1)) >= w_eff;
   assign last_row    = ({1'b0, prow_ff} + CFG_W'(1)) >= h_eff;
   assign cib_p1      = {1'b0, cib_ff} + BLK_W'(1);
   assign rib_p1      = {1'b0, rib_ff} + BLK_W'(1);
   assign col_blk_end = cib_p1 >= b_eff;
   assign row_blk_end = rib_p1 >= b_eff;
   assign tile_end    = (last_col || col_blk_end) && (last_row || row_blk_end);
   assign first_px    = (cib_ff == '0) && (rib_ff == '0);
   assign count_prod  = PROD_W'(cib_p1) * PROD_W'(rib_p1);

   always_comb begin
      pcol_in = pcol_ff;
      prow_in = prow_ff;
      tcol_in = tcol_ff;
      trow_in = trow_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      if (restart) begin
         pcol_in = '0;
         prow_in = '0;
         tcol_in = '0;
         trow_in = '0;
         cib_in  = '0;
         rib_in  = '0;
      end else if (cmd.capture) begin
         if (last_col) begin
            pcol_in = '0;
            cib_in  = '0;
            tcol_in = '0;
            if (last_row) begin
               prow_in = '0;
               rib_in  = '0;
               trow_in = '0;
            end else begin
               prow_in = prow_ff + POS_W'(1);
               if (row_blk_end) begin
                  rib_in  = '0;
                  trow_in = trow_ff + POS_W'(1);
               end else begin
                  rib_in = rib_p1[INB_W-1:0];
               end
            end
         end else begin
            pcol_in = pcol_ff + POS_W'(1);
            if (col_blk_end) begin
               cib_in  = '0;
               tcol_in = tcol_ff + POS_W'(1);
            end else begin
               cib_in = cib_p1[INB_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcol_ff <= '0;
         prow_ff <= '0;
         tcol_ff <= '0;
         trow_ff <= '0;
         cib_ff  <= '0;
         rib_ff  <= '0;
      end else begin
         pcol_ff <= pcol_in;
         prow_ff <= prow_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
         cib_ff  <= cib_in;
         rib_ff  <= rib_in;
      end
   end

   // Snapshot of the accepted pixel and of where it sits.
   logic [PIX_W-1:0] pixel_ff;
   logic             first_ff, tile_end_ff, row_end_ff, image_end_ff;
   logic [POS_W-1:0] tcol_lat_ff, trow_lat_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pixel_ff     <= req_pixel;
         first_ff     <= first_px;
         tile_end_ff  <= tile_end;
         row_end_ff   <= last_col;
         image_end_ff <= last_col && last_row;
         tcol_lat_ff  <= tcol_ff;
         trow_lat_ff  <= trow_ff;
         count_ff     <= count_prod[CNT_W-1:0];
      end
   end

   // Running sum per tile column. The first pixel of a tile overwrites its
   // entry, so the memory never needs clearing.
   logic [SUM_W-1:0] col_mem [MAX_WIDTH];
   logic [SUM_W-1:0] rd_data_ff;
   logic [SUM_W-1:0] sum_in;

   assign sum_in = first_ff ? SUM_W'(pixel_ff) : rd_data_ff + SUM_W'(pixel_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= col_mem[tcol_ff];
      end
      if (cmd.accumulate) begin
         col_mem[tcol_lat_ff] <= sum_in;
      end
   end

   // Restoring divider, one quotient bit per cycle.
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         quo_ff  <= sum_in;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], fits};
         rem_ff  <= fits ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // Average, ramp lookup and output register.
   logic [AVG_W-1:0]  avg;
   logic [RIDX_W-1:0] ridx;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff;

   assign avg  = (|quo_ff[SUM_W-1:AVG_W]) ? {AVG_W{1'b1}} : quo_ff[AVG_W-1:0];
   assign ridx = ramp_index_of(avg);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_payload_ff.ramp_index    <= ridx;
         rsp_payload_ff.char_code     <= ramp_code_of(ridx);
         rsp_payload_ff.block_average <= avg;
         rsp_payload_ff.block_column  <= tcol_lat_ff;
         rsp_payload_ff.block_row     <= trow_lat_ff;
         rsp_payload_ff.row_end       <= row_end_ff;
         rsp_payload_ff.image_end     <= image_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Status to the controller.
   assign stat.tile_end = tile_end_ff;
   assign stat.div_done = step_ff == STEP_W'(DIV_STEPS - 1);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule
